[hdl/incremental_ddt_apn_checker_assert.svh]
// Assertion macros shared by the checker of the incremental DDT APN block.
`ifndef INCREMENTAL_DDT_APN_CHECKER_ASSERT_SVH
`define INCREMENTAL_DDT_APN_CHECKER_ASSERT_SVH

// An implication that holds on the same clock edge.
`define IDDT_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// An implication whose consequence holds on the following clock edge.
`define IDDT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/iddt_pkg.sv]
// Shared types and constants of the incremental DDT APN block.
`timescale 1ns / 1ps
`default_nettype none

package iddt_pkg;

   // Fixed widths of the word fields.
   localparam int MODE_W  = 2;
   localparam int FIELD_W = 7;

   // Halved DDT counts are two bits wide and saturate at three.
   localparam int           CNT_W   = 2;
   localparam logic [1:0]   CNT_MAX = 2'd3;

   // Operation codes of the mode field; the fourth code does nothing.
   typedef enum logic [MODE_W-1:0] {
      MODE_ASSIGN = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

endpackage

`default_nettype wire

[hdl/iddt_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module iddt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[hdl/incremental_ddt_apn_checker.sv]
// Top level of the incremental DDT APN checker for a partial S-box.
`timescale 1ns / 1ps
`default_nettype none

// Incremental APN check on a partial BITS-bit S-box. Each request word carries
// a mode: assign a value to a point and check, remove a point, or clear all.
// Every request gives exactly one response word whose ok bit is low only when
// an assignment drives a halved DDT count above one. The S-box values live in
// a small RAM with one valid flip-flop per point; the halved DDT counts live
// in a 2^(2*BITS)-entry RAM. An assign or remove walks the 2^(BITS-1)-1
// nonzero even-weight differences through a three-stage pipeline (S-box read,
// DDT read, DDT write), one difference per cycle; a remove first looks up
// its old value, and one of an unset point does not walk. A failed check, or
// a remove that brings a count down to one, ends the walk early. After reset
// and after every clear request, a clearing pass writes zero to the DDT RAM
// one entry per cycle, during which no request word is taken. The request
// side is free again while a response word still waits to be taken.
module incremental_ddt_apn_checker #(
   parameter int BITS = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [iddt_pkg::MODE_W-1:0] req_mode,
   input  wire logic [iddt_pkg::FIELD_W-1:0] req_point,
   input  wire logic [iddt_pkg::FIELD_W-1:0] req_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_ok
);

   localparam int SIZE      = 1 << BITS;
   localparam int KW        = BITS - 1;
   localparam int DW        = 2 * BITS;
   localparam int DDT_DEPTH = 1 << DW;
   localparam int PW        = (BITS > iddt_pkg::FIELD_W) ? BITS : iddt_pkg::FIELD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WALK,
      ST_DRAIN,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   iddt_pkg::mode_type   mode_ff, mode_in;
   logic [BITS-1:0]      x_ff, x_in;
   logic [BITS-1:0]      y_ff, y_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [BITS-1:0]      s1_a_ff, s1_a_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic [BITS-1:0]      s2_a_ff, s2_a_in;
   logic [BITS-1:0]      s2_d_ff, s2_d_in;
   logic [DW-1:0]        clr_ff, clr_in;
   logic                 clr_reply_ff, clr_reply_in;
   logic                 res_ok_ff, res_ok_in;
   logic [SIZE-1:0]      sbox_valid_ff, sbox_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;

   logic                 accept;
   logic [PW-1:0]        point_ext;
   logic [PW-1:0]        value_ext;
   logic [BITS-1:0]      req_x;
   logic [BITS-1:0]      req_y;
   logic [BITS-1:0]      walk_a;
   logic [BITS-1:0]      walk_pt;
   logic                 out_free;

   logic                 sbox_we;
   logic [BITS-1:0]      sbox_raddr;
   logic [BITS-1:0]      sbox_rdata;
   logic                 ddt_we;
   logic [DW-1:0]        ddt_waddr;
   logic [iddt_pkg::CNT_W-1:0] ddt_wdata;
   logic [DW-1:0]        ddt_raddr;
   logic [iddt_pkg::CNT_W-1:0] ddt_rdata;
   logic [iddt_pkg::CNT_W-1:0] cnt_new;
   logic                 cnt_stop;
   logic                 stop;

   // Request fields reduced to the S-box width.
   assign point_ext = PW'(req_point);
   assign value_ext = PW'(req_value);
   assign req_x     = point_ext[BITS-1:0];
   assign req_y     = value_ext[BITS-1:0];

   // Handshake on both sides.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;

   // The walk counter k maps to the even-weight difference {k, parity(k)},
   // which runs through all nonzero even-weight values in ascending order.
   assign walk_a  = {k_ff, ^k_ff};
   assign walk_pt = x_ff ^ walk_a;

   // S-box reads: the looked-up point while idle, the walk partner otherwise.
   assign sbox_raddr = (state_ff == ST_IDLE) ? req_x : walk_pt;
   assign sbox_we    = accept && (iddt_pkg::mode_type'(req_mode) == iddt_pkg::MODE_ASSIGN);

   // Stage one addresses the DDT entry [a][y ^ S(x ^ a)].
   assign ddt_raddr = {s1_a_ff, y_ff ^ sbox_rdata};

   // Stage two updates the count; the rows of a walk differ, so no forwarding.
   always_comb begin
      if (mode_ff == iddt_pkg::MODE_REMOVE) begin
         cnt_new  = (ddt_rdata == '0) ? ddt_rdata : ddt_rdata - iddt_pkg::CNT_W'(1);
         cnt_stop = (cnt_new == iddt_pkg::CNT_W'(1));
      end else begin
         cnt_new  = (ddt_rdata == iddt_pkg::CNT_MAX) ? ddt_rdata
                                                     : ddt_rdata + iddt_pkg::CNT_W'(1);
         cnt_stop = (cnt_new > iddt_pkg::CNT_W'(1));
      end
   end

   assign stop = s2_valid_ff && cnt_stop;

   // DDT writes: zeros during the clearing pass, updated counts otherwise.
   assign ddt_we    = (state_ff == ST_CLEAR) || s2_valid_ff;
   assign ddt_waddr = (state_ff == ST_CLEAR) ? clr_ff : {s2_a_ff, s2_d_ff};
   assign ddt_wdata = (state_ff == ST_CLEAR) ? '0 : cnt_new;

   // Next-state logic of the sequencer and the walk pipeline.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      k_in          = k_ff;
      s1_valid_in   = 1'b0;
      s1_a_in       = walk_a;
      s2_valid_in   = s1_valid_ff;
      s2_a_in       = s1_a_ff;
      s2_d_in       = y_ff ^ sbox_rdata;
      clr_in        = clr_ff;
      clr_reply_in  = clr_reply_ff;
      res_ok_in     = res_ok_ff;
      sbox_valid_in = sbox_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = iddt_pkg::mode_type'(req_mode);
               x_in      = req_x;
               y_in      = req_y;
               res_ok_in = 1'b1;
               k_in      = KW'(1);
               unique case (iddt_pkg::mode_type'(req_mode))
                  iddt_pkg::MODE_ASSIGN: begin
                     sbox_valid_in[req_x] = 1'b1;
                     state_in             = ST_WALK;
                  end
                  iddt_pkg::MODE_REMOVE: begin
                     state_in = sbox_valid_ff[req_x] ? ST_LOOKUP : ST_FINISH;
                  end
                  iddt_pkg::MODE_CLEAR: begin
                     sbox_valid_in = '0;
                     clr_in        = '0;
                     clr_reply_in  = 1'b1;
                     state_in      = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            y_in     = sbox_rdata;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            s1_valid_in = sbox_valid_ff[walk_pt];
            k_in        = k_ff + KW'(1);
            if (k_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + DW'(1);
            if (clr_ff == '1) begin
               state_in = clr_reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               if (mode_ff == iddt_pkg::MODE_REMOVE) begin
                  sbox_valid_in[x_ff] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A count that crosses its limit ends the walk and flushes the pipeline.
      if (stop) begin
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b0;
         state_in    = ST_FINISH;
         if (mode_ff == iddt_pkg::MODE_ASSIGN) begin
            res_ok_in = 1'b0;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      k_ff          <= k_in;
      s1_a_ff       <= s1_a_in;
      s2_a_ff       <= s2_a_in;
      s2_d_ff       <= s2_d_in;
      res_ok_ff     <= res_ok_in;
      rsp_ok_ff     <= rsp_ok_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         clr_reply_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         sbox_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         clr_reply_ff  <= clr_reply_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         sbox_valid_ff <= sbox_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // S-box values; validity is kept in flip-flops above.
   iddt_ram #(
      .WIDTH (BITS),
      .DEPTH (SIZE)
   ) u_sbox_ram (
      .clock (clock),
      .we    (sbox_we),
      .waddr (req_x),
      .wdata (req_y),
      .raddr (sbox_raddr),
      .rdata (sbox_rdata)
   );

   // Halved DDT counts, indexed [a][d].
   iddt_ram #(
      .WIDTH (iddt_pkg::CNT_W),
      .DEPTH (DDT_DEPTH)
   ) u_ddt_ram (
      .clock (clock),
      .we    (ddt_we),
      .waddr (ddt_waddr),
      .wdata (ddt_wdata),
      .raddr (ddt_raddr),
      .rdata (ddt_rdata)
   );

endmodule

`default_nettype wire

[hdl/iddt_checker.sv]
// Port-level assertions of the incremental DDT APN block and their bind.
`timescale 1ns / 1ps
`default_nettype none

`include "incremental_ddt_apn_checker_assert.svh"

module iddt_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic [iddt_pkg::MODE_W-1:0] req_mode,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic                        rsp_ok
);

   logic       push;
   logic       pop;
   logic       not_assign;
   logic [1:0] count_ff, count_in;
   logic [1:0] count_mid;
   logic [1:0] q_ff, q_in;

   assign push       = req_valid && !req_stall;
   assign pop        = rsp_valid && !rsp_stall;
   assign not_assign = (req_mode != iddt_pkg::MODE_W'(iddt_pkg::MODE_ASSIGN));

   // Track, in order, which outstanding words must answer with ok set.
   always_comb begin
      q_in      = q_ff;
      count_mid = count_ff;
      if (pop && (count_ff != 2'd0)) begin
         q_in      = {1'b0, q_ff[1]};
         count_mid = count_ff - 2'd1;
      end
      if (push) begin
         q_in[count_mid[0]] = not_assign;
      end
      count_in = count_mid + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         q_ff     <= '0;
      end else begin
         count_ff <= count_in;
         q_ff     <= q_in;
      end
   end

   `IDDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_ok), "stalled response word changed")
   `IDDT_ASSERT_NEXT(a_busy_after_accept, clock, reset, push, req_stall, "request side free right after taking a word")
   `IDDT_ASSERT_NOW(a_rsp_has_request, clock, reset, rsp_valid, count_ff != 2'd0, "response word without a request")
   `IDDT_ASSERT_NOW(a_ok_non_assign, clock, reset, rsp_valid && q_ff[0], rsp_ok, "remove, clear or idle word answered with ok low")

endmodule

bind incremental_ddt_apn_checker iddt_checker u_iddt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_mode  (req_mode),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_ok    (rsp_ok)
);

`default_nettype wire

[tb/incremental_ddt_apn_checker_tb.sv]
// Self-checking testbench for the incremental DDT APN checker of a partial S-box.
`timescale 1ns / 1ps

module incremental_ddt_apn_checker_tb;

   localparam int SBOX_BITS  = 7;
   localparam int SBOX_SIZE  = 1 << SBOX_BITS;
   localparam int TABLE_SIZE = SBOX_SIZE * SBOX_SIZE;

   // The fourth mode code is accepted and answered but changes nothing.
   localparam logic [iddt_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int HOLD_CYCLES   = 500;
   localparam int DRAIN_CYCLES  = 100;
   localparam int PHASE_WORDS   = 260;
   localparam int DIRECTED_ROWS = 23;

   // One directed request word; typed rows carry an ok bit read off by hand.
   typedef struct packed {
      logic [iddt_pkg::MODE_W-1:0]  mode;
      logic [iddt_pkg::FIELD_W-1:0] point;
      logic [iddt_pkg::FIELD_W-1:0] value;
      logic                         typed;
      logic                         ok;
   } stim_row_type;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{MODE_IGNORED,          7'd127, 7'd127, 1'b1, 1'b1},  // ignored code right after reset
      '{iddt_pkg::MODE_REMOVE, 7'd0,   7'd127, 1'b1, 1'b1},  // remove of an unset point
      '{iddt_pkg::MODE_ASSIGN, 7'd0,   7'd0,   1'b1, 1'b1},  // first point of an empty box
      '{iddt_pkg::MODE_ASSIGN, 7'd3,   7'h05,  1'b0, 1'b0},
      '{iddt_pkg::MODE_ASSIGN, 7'd5,   7'h11,  1'b0, 1'b0},
      '{iddt_pkg::MODE_ASSIGN, 7'd6,   7'h14,  1'b0, 1'b0},  // collides on difference 3
      '{iddt_pkg::MODE_ASSIGN, 7'd6,   7'h14,  1'b0, 1'b0},  // overwrite, count climbs to 3
      '{iddt_pkg::MODE_ASSIGN, 7'd6,   7'h14,  1'b0, 1'b0},  // count stays saturated
      '{iddt_pkg::MODE_REMOVE, 7'd6,   7'h55,  1'b1, 1'b1},
      '{iddt_pkg::MODE_REMOVE, 7'd5,   7'd0,   1'b1, 1'b1},  // walks entries already at zero
      '{iddt_pkg::MODE_REMOVE, 7'd5,   7'd0,   1'b1, 1'b1},
      '{iddt_pkg::MODE_ASSIGN, 7'd127, 7'd127, 1'b0, 1'b0},
      '{iddt_pkg::MODE_ASSIGN, 7'd124, 7'h7a,  1'b0, 1'b0},
      '{iddt_pkg::MODE_ASSIGN, 7'd127, 7'd0,   1'b0, 1'b0},
      '{iddt_pkg::MODE_REMOVE, 7'd127, 7'd64,  1'b1, 1'b1},
      '{iddt_pkg::MODE_REMOVE, 7'd124, 7'd1,   1'b1, 1'b1},
      '{iddt_pkg::MODE_REMOVE, 7'd3,   7'd0,   1'b1, 1'b1},
      '{iddt_pkg::MODE_REMOVE, 7'd0,   7'd127, 1'b1, 1'b1},
      '{MODE_IGNORED,          7'd0,   7'd0,   1'b1, 1'b1},
      '{iddt_pkg::MODE_CLEAR,  7'd85,  7'd42,  1'b1, 1'b1},
      '{iddt_pkg::MODE_ASSIGN, 7'd42,  7'd85,  1'b1, 1'b1},  // first point after a clear
      '{iddt_pkg::MODE_ASSIGN, 7'd85,  7'd42,  1'b0, 1'b0},
      '{iddt_pkg::MODE_CLEAR,  7'd127, 7'd127, 1'b1, 1'b1}
   };

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [iddt_pkg::MODE_W-1:0]  req_mode;
   logic [iddt_pkg::FIELD_W-1:0] req_point;
   logic [iddt_pkg::FIELD_W-1:0] req_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_ok;

   // Predicted state of the partial S-box and of the halved DDT counts.
   bit                           sbox_set [SBOX_SIZE];
   bit [iddt_pkg::FIELD_W-1:0]   sbox_out [SBOX_SIZE];
   bit [iddt_pkg::CNT_W-1:0]     half_count [TABLE_SIZE];

   bit                           apn_ok_expected [$];
   int                           cycles;
   int                           mismatches;
   int                           words_checked;
   int                           apn_failures;
   int                           clear_count;
   int                           send_idle_pct;
   int                           rsp_idle_pct;
   int                           hold_requests;
   int                           hold_served;
   int                           hold_left;
   bit                           fail_pending;
   logic [iddt_pkg::FIELD_W-1:0] fail_point;

   incremental_ddt_apn_checker #(
      .BITS(SBOX_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_point (req_point),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_ok    (rsp_ok)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle counter and the overall run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding", cycles,
                  apn_ok_expected.size());
         $display("incremental_ddt_apn_checker_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string why);
      $display("MISMATCH at cycle %0d: %s", cycles, why);
      mismatches++;
   endtask

   function automatic void clear_model();
      for (int i = 0; i < SBOX_SIZE; i++) begin
         sbox_set[i] = 1'b0;
         sbox_out[i] = '0;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
         half_count[i] = '0;
      end
   endfunction

   // Applies one request word to the predicted state and returns its ok bit.
   function automatic bit predict_word(input logic [iddt_pkg::MODE_W-1:0] mode,
                                       input logic [iddt_pkg::FIELD_W-1:0] x,
                                       input logic [iddt_pkg::FIELD_W-1:0] y);
      bit                             ok;
      bit                             stop;
      logic [iddt_pkg::FIELD_W-1:0]   diff;
      logic [iddt_pkg::FIELD_W-1:0]   partner;
      logic [iddt_pkg::FIELD_W-1:0]   own;
      logic [2*iddt_pkg::FIELD_W-1:0] slot;
      ok = 1'b1;
      stop = 1'b0;
      if (mode == iddt_pkg::MODE_ASSIGN) begin
         sbox_set[x] = 1'b1;
         sbox_out[x] = y;
         // Bump counts along the even-weight differences until one passes 1.
         for (int a = 1; a < SBOX_SIZE; a++) begin
            diff = a[iddt_pkg::FIELD_W-1:0];
            partner = x ^ diff;
            if (!stop && ^diff == 1'b0 && sbox_set[partner]) begin
               slot = {diff, y ^ sbox_out[partner]};
               if (half_count[slot] != iddt_pkg::CNT_MAX) half_count[slot]++;
               if (half_count[slot] > 2'd1) begin
                  ok = 1'b0;
                  stop = 1'b1;
               end
            end
         end
         if (!ok) apn_failures++;
      end else if (mode == iddt_pkg::MODE_REMOVE) begin
         if (sbox_set[x]) begin
            own = sbox_out[x];
            // Undo in the same order; stop right after a count lands on 1.
            for (int a = 1; a < SBOX_SIZE; a++) begin
               diff = a[iddt_pkg::FIELD_W-1:0];
               partner = x ^ diff;
               if (!stop && ^diff == 1'b0 && sbox_set[partner]) begin
                  slot = {diff, own ^ sbox_out[partner]};
                  if (half_count[slot] != 2'd0) half_count[slot]--;
                  if (half_count[slot] == 2'd1) stop = 1'b1;
               end
            end
            sbox_set[x] = 1'b0;
         end
      end else if (mode == iddt_pkg::MODE_CLEAR) begin
         clear_model();
         clear_count++;
      end
      return ok;
   endfunction

   // Finds a point that is set or unset, starting at a random place; -1 if none.
   function automatic int pick_point(input bit want_set);
      int start;
      start = $urandom_range(0, SBOX_SIZE - 1);
      for (int k = 0; k < SBOX_SIZE; k++) begin
         if (sbox_set[(start + k) % SBOX_SIZE] == want_set) return (start + k) % SBOX_SIZE;
      end
      return -1;
   endfunction

   // Offers one request word after random idle cycles and records its outcome.
   task automatic send_word(input logic [iddt_pkg::MODE_W-1:0] mode,
                            input logic [iddt_pkg::FIELD_W-1:0] pt,
                            input logic [iddt_pkg::FIELD_W-1:0] val, input bit typed,
                            input bit typed_ok);
      bit predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_point <= pt;
      req_value <= val;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_word(mode, pt, val);
      apn_ok_expected.push_back(typed ? typed_ok : predicted);
      fail_pending = (mode == iddt_pkg::MODE_ASSIGN) && !predicted;
      fail_point = pt;
   endtask

   // Receiver stall: random idling, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Compare each accepted response word with the oldest expected ok bit.
   always @(posedge clock) begin : check_response
      bit want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         words_checked++;
         if (apn_ok_expected.size() == 0) begin
            report_mismatch("response word with no request outstanding");
         end else begin
            want = apn_ok_expected.pop_front();
            if (rsp_ok !== want) begin
               report_mismatch($sformatf("word %0d: ok %b, predicted %b",
                                         words_checked, rsp_ok, want));
            end
         end
      end
   end

   // Stimulus: reset, directed words, then three random phases with different idling.
   initial begin
      logic [iddt_pkg::MODE_W-1:0]  mode;
      logic [iddt_pkg::FIELD_W-1:0] pt;
      logic [iddt_pkg::FIELD_W-1:0] val;
      int                           pick;
      int                           r;
      int                           phase_words;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_IGNORED;
      req_point = '0;
      req_value = '0;
      rsp_stall = 1'b0;
      clear_model();
      send_idle_pct = 30;
      rsp_idle_pct = 30;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_word(directed_rows[i].mode, directed_rows[i].point, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].ok);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 16;
               rsp_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               rsp_idle_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         send_word(iddt_pkg::MODE_CLEAR, iddt_pkg::FIELD_W'($urandom_range(0, 127)),
                   iddt_pkg::FIELD_W'($urandom_range(0, 127)), 1'b0, 1'b0);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            // Long receiver hold-off while the sender keeps offering words.
            if (phase == 2 && phase_words == 5) hold_requests++;
            pt = iddt_pkg::FIELD_W'($urandom_range(0, 127));
            val = iddt_pkg::FIELD_W'($urandom_range(0, 127));
            mode = iddt_pkg::MODE_ASSIGN;
            if (fail_pending && $urandom_range(0, 3) != 0) begin
               // Backtrack: take back the assignment that broke the APN property.
               mode = iddt_pkg::MODE_REMOVE;
               pt = fail_point;
            end else begin
               r = $urandom_range(0, 199);
               if (r == 0) begin
                  mode = iddt_pkg::MODE_CLEAR;
               end else if (r < 110) begin
                  pick = pick_point(1'b0);
                  if (pick >= 0) pt = pick[iddt_pkg::FIELD_W-1:0];
               end else if (r < 160) begin
                  pick = pick_point(1'b1);
                  if (pick >= 0) begin
                     mode = iddt_pkg::MODE_REMOVE;
                     pt = pick[iddt_pkg::FIELD_W-1:0];
                  end
               end else if (r < 175) begin
                  pick = pick_point(1'b1);
                  if (pick >= 0) pt = pick[iddt_pkg::FIELD_W-1:0];
               end else if (r < 185) begin
                  mode = iddt_pkg::MODE_REMOVE;
                  pick = pick_point(1'b0);
                  if (pick >= 0) pt = pick[iddt_pkg::FIELD_W-1:0];
               end else if (r < 192) begin
                  mode = MODE_IGNORED;
               end else begin
                  mode = iddt_pkg::MODE_W'($urandom_range(0, 3));
                  if (mode == iddt_pkg::MODE_CLEAR) mode = MODE_IGNORED;
               end
            end
            if (!(mode == MODE_IGNORED || (mode == iddt_pkg::MODE_REMOVE && !sbox_set[pt])))
               phase_words++;
            send_word(mode, pt, val, 1'b0, 1'b0);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (apn_ok_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d response words, %0d failed APN checks, %0d clears, %0d cycles",
               words_checked, apn_failures, clear_count, cycles);
      $display("Idling ran sender-heavy, receiver-heavy and none, with one long hold-off");
      if (mismatches == 0) begin
         $display("incremental_ddt_apn_checker_tb passed");
      end else begin
         $display("incremental_ddt_apn_checker_tb failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/iddt_pkg.sv
hdl/iddt_ram.sv
hdl/incremental_ddt_apn_checker.sv
hdl/iddt_checker.sv
tb/incremental_ddt_apn_checker_tb.sv
